// File: hdl/prefix_substring_suffix_matcher_defines.svh
// Assertion macros shared by the prefix / substring / suffix matcher.
// Each macro expects signals named clk and rst in the including scope.
`ifndef PREFIX_SUBSTRING_SUFFIX_MATCHER_DEFINES_SVH
`define PREFIX_SUBSTRING_SUFFIX_MATCHER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/psm_pkg.sv
// Package for the prefix / substring / suffix matcher.
// Holds widths, register indexes, mode codes and the cell control type.
`timescale 1ns / 1ps

package psm_pkg;

  localparam int MAX_NEEDLE_DEFAULT = 16;
  localparam int NEEDLE_SLOTS       = 16;
  localparam int BYTE_W             = 8;
  localparam int LEN_W              = 5;
  localparam int MODE_W             = 2;
  localparam int CFG_DATA_W         = 64;
  localparam int CFG_INDEX_W        = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_MATCH_MODE   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WANT_MATCH   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_NEEDLE_LEN   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_NEEDLE_LOW   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_NEEDLE_HIGH  = 3'd4;

  localparam logic [MODE_W-1:0] MODE_BEGINS   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CONTAINS = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ENDS     = 2'd2;

  typedef struct packed {
    logic shift_en;
    logic in_use;
  } psm_cell_ctrl_t;

endpackage

// File: hdl/psm_cell.sv
// One window cell of the matcher: holds one subject byte and compares it.
// Depends on psm_pkg for the byte width and the cell control type.
`timescale 1ns / 1ps

module psm_cell (
  input  logic                        clk,
  input  psm_pkg::psm_cell_ctrl_t     ctrl,
  input  logic [psm_pkg::BYTE_W-1:0]  shift_in,
  input  logic [psm_pkg::BYTE_W-1:0]  expect_byte,
  output logic [psm_pkg::BYTE_W-1:0]  stored,
  output logic                        hit
);
  import psm_pkg::*;

  logic [BYTE_W-1:0] candidate;

  // The compare sees the byte this cell holds after the current beat.
  assign candidate = ctrl.shift_en ? shift_in : stored;
  assign hit       = !ctrl.in_use || (candidate == expect_byte);

  always_ff @(posedge clk) begin
    if (ctrl.shift_en) begin
      stored <= shift_in;
    end
  end

endmodule

// File: hdl/prefix_substring_suffix_matcher.sv
// Top level of the prefix / substring / suffix matcher: window cell chain,
// byte count, found flag, configuration registers and result register.
// Depends on psm_pkg, psm_cell and prefix_substring_suffix_matcher_defines.svh.
//
//   Channel  Handshake            Payload
//   in       in_valid / in_ready  subject_byte, last_byte, no_byte
//   out      out_valid/out_ready  needle_found, rule_passes
//   cfg      cfg_we               cfg_index, cfg_data
//
// One input beat is taken every cycle while in_ready is high; a beat with last_byte set yields its result
// in the output register in the cycle after it is accepted.
// The needle compare runs in parallel across the cell chain within the accepting cycle.
// Input stalls only while a result waits in the output register and out_ready is low.
// Reset is synchronous; it clears the count, the flag and out_valid, and loads the register defaults.
`timescale 1ns / 1ps
`include "prefix_substring_suffix_matcher_defines.svh"

module prefix_substring_suffix_matcher #(
  parameter int MAX_NEEDLE = psm_pkg::MAX_NEEDLE_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [psm_pkg::BYTE_W-1:0]        subject_byte,
  input  logic                              last_byte,
  input  logic                              no_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              needle_found,
  output logic                              rule_passes,
  input  logic                              cfg_we,
  input  logic [psm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [psm_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import psm_pkg::*;

  localparam int CNT_W = $clog2(MAX_NEEDLE + 1);

  logic [MODE_W-1:0]     match_mode;
  logic                  want_match;
  logic [LEN_W-1:0]      needle_length;
  logic [CFG_DATA_W-1:0] needle_bytes_low;
  logic [CFG_DATA_W-1:0] needle_bytes_high;

  logic [CNT_W-1:0]      bytes_seen;
  logic [CNT_W-1:0]      bytes_seen_next;
  logic                  found_flag;
  logic                  found_flag_next;

  logic                  accept;
  logic                  byte_in;
  logic [LEN_W-1:0]      n_eff;
  logic [LEN_W-1:0]      prev_cnt;
  logic [LEN_W-1:0]      new_cnt;
  logic                  window_hit;
  logic                  begins_hit;
  logic                  contains_hit;
  logic                  ends_hit;
  logic                  result_found;

  logic [BYTE_W-1:0]     needle  [NEEDLE_SLOTS];
  logic [BYTE_W-1:0]     window  [MAX_NEEDLE];
  logic [BYTE_W-1:0]     expects [MAX_NEEDLE];
  logic [MAX_NEEDLE-1:0] hits;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign byte_in  = accept && !no_byte;

  always_comb begin
    if (needle_length == '0) begin
      n_eff = LEN_W'(1);
    end else if (needle_length > LEN_W'(MAX_NEEDLE)) begin
      n_eff = LEN_W'(MAX_NEEDLE);
    end else begin
      n_eff = needle_length;
    end
  end

  for (genvar k = 0; k < NEEDLE_SLOTS / 2; k++) begin : g_needle
    assign needle[k]                    = needle_bytes_low[BYTE_W*k +: BYTE_W];
    assign needle[k + NEEDLE_SLOTS / 2] = needle_bytes_high[BYTE_W*k +: BYTE_W];
  end

  for (genvar j = 0; j < MAX_NEEDLE; j++) begin : g_cell
    logic [LEN_W-1:0] slot;
    psm_cell_ctrl_t   ctrl;
    logic [BYTE_W-1:0] shift_in;

    // Cell j holds the byte that lines up with needle byte n - 1 - j.
    assign slot          = n_eff - LEN_W'(j) - LEN_W'(1);
    assign expects[j]    = needle[slot[$clog2(NEEDLE_SLOTS)-1:0]];
    assign ctrl.shift_en = byte_in;
    assign ctrl.in_use   = LEN_W'(j) < n_eff;

    if (j == 0) begin : g_head
      assign shift_in = subject_byte;
    end else begin : g_link
      assign shift_in = window[j-1];
    end

    psm_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .shift_in    (shift_in),
      .expect_byte (expects[j]),
      .stored      (window[j]),
      .hit         (hits[j])
    );
  end

  assign window_hit = &hits;

  always_comb begin
    bytes_seen_next = bytes_seen;
    if (byte_in && (bytes_seen < CNT_W'(MAX_NEEDLE))) begin
      bytes_seen_next = bytes_seen + CNT_W'(1);
    end
  end

  assign prev_cnt     = LEN_W'(bytes_seen);
  assign new_cnt      = LEN_W'(bytes_seen_next);
  assign begins_hit   = byte_in && (prev_cnt < n_eff) && (new_cnt == n_eff) && window_hit;
  assign contains_hit = byte_in && (new_cnt >= n_eff) && window_hit;
  assign ends_hit     = (new_cnt >= n_eff) && window_hit;

  always_comb begin
    case (match_mode)
      MODE_BEGINS: begin
        found_flag_next = found_flag || begins_hit;
        result_found    = found_flag_next;
      end
      MODE_CONTAINS: begin
        found_flag_next = found_flag || contains_hit;
        result_found    = found_flag_next;
      end
      MODE_ENDS: begin
        found_flag_next = found_flag;
        result_found    = ends_hit;
      end
      default: begin
        found_flag_next = found_flag;
        result_found    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_mode        <= MODE_BEGINS;
      want_match        <= 1'b1;
      needle_length     <= LEN_W'(1);
      needle_bytes_low  <= '0;
      needle_bytes_high <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MATCH_MODE:  match_mode        <= cfg_data[MODE_W-1:0];
        REG_WANT_MATCH:  want_match        <= cfg_data[0];
        REG_NEEDLE_LEN:  needle_length     <= cfg_data[LEN_W-1:0];
        REG_NEEDLE_LOW:  needle_bytes_low  <= cfg_data;
        REG_NEEDLE_HIGH: needle_bytes_high <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
      found_flag <= 1'b0;
    end else if (accept) begin
      if (last_byte) begin
        bytes_seen <= '0;
        found_flag <= 1'b0;
      end else begin
        bytes_seen <= bytes_seen_next;
        found_flag <= found_flag_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && last_byte) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_byte) begin
      needle_found <= result_found;
      rule_passes  <= (result_found == want_match);
    end
  end

  `PSM_ASSERT_NOW(a_count_saturates, 1'b1, bytes_seen <= CNT_W'(MAX_NEEDLE), "Byte count passed the window depth.")
  `PSM_ASSERT_NEXT(a_last_gives_result, accept && last_byte, out_valid, "Last beat did not load a result.")
  `PSM_ASSERT_NEXT(a_last_clears, accept && last_byte, bytes_seen == '0 && !found_flag, "Subject state not cleared after last beat.")
  `PSM_ASSERT_NOW(a_stall_only_on_full, !in_ready, out_valid && !out_ready, "Input stalled with room in the output register.")

endmodule

// File: tb/prefix_substring_suffix_matcher_tb.sv
// Self-checking testbench for prefix_substring_suffix_matcher: directed subjects, then
// randomized phases of configuration and streamed subjects under random idling on both sides.
// Depends on psm_pkg and the matcher RTL; a scoreboard class predicts every match verdict.
`timescale 1ns / 1ps

module prefix_substring_suffix_matcher_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_BEATS = 1450;
  localparam int PHASE_BEATS = 120;
  localparam logic [psm_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic found;
    logic passes;
  } verdict_t;

  class match_scoreboard;
    logic [psm_pkg::MODE_W-1:0] mode;
    logic want;
    logic [psm_pkg::LEN_W-1:0] needle_len;
    logic [63:0] needle_low;
    logic [63:0] needle_high;
    logic [7:0] window_bytes [psm_pkg::NEEDLE_SLOTS];
    int seen;
    logic found_flag;
    verdict_t verdict_q[$];
    int errors;

    function new();
      mode = psm_pkg::MODE_BEGINS;
      want = 1'b1;
      needle_len = 5'd1;
      needle_low = '0;
      needle_high = '0;
      errors = 0;
      clear_subject();
    endfunction

    function void clear_subject();
      foreach (window_bytes[k]) window_bytes[k] = 8'h00;
      seen = 0;
      found_flag = 1'b0;
    endfunction

    function void write_reg(logic [psm_pkg::CFG_INDEX_W-1:0] idx, logic [63:0] data);
      case (idx)
        psm_pkg::REG_MATCH_MODE: mode = data[1:0];
        psm_pkg::REG_WANT_MATCH: want = data[0];
        psm_pkg::REG_NEEDLE_LEN: needle_len = data[4:0];
        psm_pkg::REG_NEEDLE_LOW: needle_low = data;
        psm_pkg::REG_NEEDLE_HIGH: needle_high = data;
        default: ;
      endcase
    endfunction

    function int needle_span();
      if (needle_len == 0) return 1;
      if (needle_len > psm_pkg::NEEDLE_SLOTS) return psm_pkg::NEEDLE_SLOTS;
      return needle_len;
    endfunction

    function logic [7:0] needle_byte(int k);
      if (k < 8) return needle_low[8*k +: 8];
      return needle_high[8*(k-8) +: 8];
    endfunction

    function bit window_hit(int n);
      for (int k = 0; k < n; k++) begin
        if (window_bytes[n-1-k] != needle_byte(k)) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_beat(logic [7:0] b, logic last, logic empty_beat);
      int n;
      int prev;
      verdict_t v;
      n = needle_span();
      if (!empty_beat) begin
        prev = seen;
        for (int k = psm_pkg::NEEDLE_SLOTS - 1; k > 0; k--) window_bytes[k] = window_bytes[k-1];
        window_bytes[0] = b;
        if (seen < psm_pkg::NEEDLE_SLOTS) seen++;
        if (mode == psm_pkg::MODE_BEGINS) begin
          if (prev < n && seen == n && window_hit(n)) found_flag = 1'b1;
        end else if (mode == psm_pkg::MODE_CONTAINS) begin
          if (seen >= n && window_hit(n)) found_flag = 1'b1;
        end
      end
      if (!last) return;
      if (mode == psm_pkg::MODE_ENDS) v.found = (seen >= n) && window_hit(n);
      else if (mode == MODE_UNUSED) v.found = 1'b0;
      else v.found = found_flag;
      v.passes = (v.found == want);
      verdict_q.push_back(v);
      clear_subject();
    endfunction

    function void check_verdict(logic found, logic passes);
      verdict_t v;
      if (verdict_q.size() == 0) begin
        $display("%0t: result beat with none expected: needle_found %0b rule_passes %0b",
                 $time, found, passes);
        errors++;
        return;
      end
      v = verdict_q.pop_front();
      if (found !== v.found) begin
        $display("%0t: needle_found expected %0b actual %0b", $time, v.found, found);
        errors++;
      end
      if (passes !== v.passes) begin
        $display("%0t: rule_passes expected %0b actual %0b", $time, v.passes, passes);
        errors++;
      end
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction

    function void report_leftover();
      if (verdict_q.size() > 0) begin
        $display("%0t: %0d results expected but never seen, next expected found %0b",
                 $time, verdict_q.size(), verdict_q[0].found);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [psm_pkg::BYTE_W-1:0] subject_byte;
  logic last_byte;
  logic no_byte;
  logic out_valid;
  logic out_ready;
  logic needle_found;
  logic rule_passes;
  logic cfg_we;
  logic [psm_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [psm_pkg::CFG_DATA_W-1:0] cfg_data;

  match_scoreboard sb;
  int idle_style;
  int beat_count;
  int cycle_count;
  logic [7:0] alphabet [4];
  int alpha_size;

  prefix_substring_suffix_matcher DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .subject_byte(subject_byte),
    .last_byte(last_byte),
    .no_byte(no_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .needle_found(needle_found),
    .rule_passes(rule_passes),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int draw_gap();
    case (idle_style)
      0: return 0;
      1: return $urandom_range(0, 12);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
    endcase
  endfunction

  function automatic logic [7:0] pick_byte();
    if (alpha_size == 0 || $urandom_range(0, 15) == 0) return 8'($urandom_range(0, 255));
    return alphabet[$urandom_range(0, alpha_size - 1)];
  endfunction

  task automatic send_beat(input logic [7:0] b, input logic last, input logic empty_beat);
    int gap;
    gap = draw_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    subject_byte = b;
    last_byte = last;
    no_byte = empty_beat;
    do @(posedge clk); while (!in_ready);
    sb.note_beat(b, last, empty_beat);
    if (!empty_beat || last) beat_count++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [psm_pkg::CFG_INDEX_W-1:0] idx, input logic [63:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_subject(input logic ends_subject);
    logic [7:0] bytes_q[$];
    int n;
    int kind;
    int pre;
    int suf;
    int bad;
    logic tail_empty;
    n = sb.needle_span();
    kind = $urandom_range(0, 9);
    if (kind >= 1 && kind <= 3) begin
      repeat ($urandom_range(1, 20)) bytes_q.push_back(pick_byte());
    end else if (kind > 3) begin
      pre = (sb.mode == psm_pkg::MODE_BEGINS && $urandom_range(0, 3) != 0) ? 0 :
            $urandom_range(0, 5);
      suf = (sb.mode == psm_pkg::MODE_ENDS && $urandom_range(0, 3) != 0) ? 0 :
            $urandom_range(0, 5);
      bad = ($urandom_range(0, 7) == 0) ? $urandom_range(0, n - 1) : -1;
      repeat (pre) bytes_q.push_back(pick_byte());
      for (int k = 0; k < n; k++) begin
        bytes_q.push_back((k == bad) ? ~sb.needle_byte(k) : sb.needle_byte(k));
      end
      repeat (suf) bytes_q.push_back(pick_byte());
    end
    tail_empty = ends_subject && (bytes_q.size() == 0 || $urandom_range(0, 5) == 0);
    for (int k = 0; k < bytes_q.size(); k++) begin
      if ($urandom_range(0, 11) == 0) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      send_beat(bytes_q[k], ends_subject && !tail_empty && k == bytes_q.size() - 1, 1'b0);
    end
    if (tail_empty) send_beat(8'($urandom_range(0, 255)), 1'b1, 1'b1);
  endtask

  task automatic configure_phase(input int p);
    logic [63:0] low;
    logic [63:0] high;
    logic [4:0] len_extremes [4];
    logic [7:0] b;
    len_extremes[0] = 5'd0;
    len_extremes[1] = 5'd16;
    len_extremes[2] = 5'd17;
    len_extremes[3] = 5'd31;
    case ($urandom_range(0, 3))
      0: begin
        alphabet[0] = 8'h00;
        alphabet[1] = 8'hFF;
        alpha_size = 2;
      end
      1: alpha_size = 0;
      default: begin
        foreach (alphabet[k]) alphabet[k] = 8'($urandom_range(0, 255));
        alpha_size = $urandom_range(2, 4);
      end
    endcase
    for (int k = 0; k < 16; k++) begin
      b = (alpha_size == 0) ? 8'($urandom_range(0, 255)) :
          alphabet[$urandom_range(0, alpha_size - 1)];
      if (k < 8) low[8*k +: 8] = b;
      else high[8*(k-8) +: 8] = b;
    end
    write_reg(psm_pkg::REG_MATCH_MODE,
              ($urandom_range(0, 7) == 0) ? 64'(MODE_UNUSED) : 64'($urandom_range(0, 2)));
    write_reg(psm_pkg::REG_WANT_MATCH, 64'($urandom_range(0, 1)));
    write_reg(psm_pkg::REG_NEEDLE_LEN,
              (p % 4 == 0) ? 64'(len_extremes[(p / 4) % 4]) : 64'($urandom_range(1, 6)));
    write_reg(psm_pkg::REG_NEEDLE_LOW, low);
    write_reg(psm_pkg::REG_NEEDLE_HIGH, high);
    idle_style = p % 3;
  endtask

  initial begin
    out_ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      int stall;
      stall = draw_gap();
      @(negedge clk);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_verdict(needle_found, rule_passes);
    end
  end

  initial begin
    int base;
    int phase_start;
    int p;
    rst = 1'b1;
    in_valid = 1'b0;
    subject_byte = 8'h00;
    last_byte = 1'b0;
    no_byte = 1'b0;
    cfg_we = 1'b0;
    cfg_index = psm_pkg::REG_MATCH_MODE;
    cfg_data = '0;
    idle_style = 0;
    beat_count = 0;
    alpha_size = 0;
    sb = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset configuration: begins-with a single zero byte, then an empty subject.
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'h00, 1'b1, 1'b1);
    drain();

    write_reg(psm_pkg::REG_WANT_MATCH, 64'd0);
    write_reg(psm_pkg::REG_NEEDLE_LEN, 64'd3);
    write_reg(psm_pkg::REG_NEEDLE_LOW, 64'h0000_0000_0063_6261);
    write_reg(psm_pkg::REG_NEEDLE_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
    // A subject shorter than the needle never matches.
    send_beat(8'h61, 1'b0, 1'b0);
    send_beat(8'h62, 1'b1, 1'b0);
    // An empty beat inside a subject is skipped.
    send_beat(8'h61, 1'b0, 1'b0);
    send_beat(8'hFF, 1'b0, 1'b1);
    send_beat(8'h62, 1'b0, 1'b0);
    send_beat(8'h63, 1'b0, 1'b0);
    send_beat(8'hFF, 1'b1, 1'b0);
    drain();

    write_reg(psm_pkg::REG_MATCH_MODE, 64'(psm_pkg::MODE_CONTAINS));
    write_reg(psm_pkg::REG_WANT_MATCH, 64'd1);
    // The subject ends on an empty beat after some bytes.
    send_beat(8'h78, 1'b0, 1'b0);
    send_beat(8'h61, 1'b0, 1'b0);
    send_beat(8'h62, 1'b0, 1'b0);
    send_beat(8'h63, 1'b0, 1'b0);
    send_beat(8'h00, 1'b1, 1'b1);
    drain();

    write_reg(psm_pkg::REG_MATCH_MODE, 64'(psm_pkg::MODE_ENDS));
    send_beat(8'h61, 1'b0, 1'b0);
    send_beat(8'h62, 1'b0, 1'b0);
    send_beat(8'h63, 1'b0, 1'b0);
    send_beat(8'h00, 1'b1, 1'b1);
    drain();

    // Unused mode never matches; a zero needle length acts as one byte.
    write_reg(psm_pkg::REG_MATCH_MODE, 64'(MODE_UNUSED));
    write_reg(psm_pkg::REG_NEEDLE_LEN, 64'd0);
    write_reg(psm_pkg::REG_NEEDLE_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
    send_beat(8'hFF, 1'b1, 1'b0);
    drain();
    write_reg(psm_pkg::REG_MATCH_MODE, 64'(psm_pkg::MODE_ENDS));
    send_beat(8'hFF, 1'b1, 1'b0);
    drain();

    // A mode change in the middle of a subject keeps the flag already set.
    write_reg(psm_pkg::REG_MATCH_MODE, 64'(psm_pkg::MODE_CONTAINS));
    write_reg(psm_pkg::REG_NEEDLE_LEN, 64'd1);
    write_reg(psm_pkg::REG_NEEDLE_LOW, 64'h0000_0000_0000_0041);
    send_beat(8'h41, 1'b0, 1'b0);
    drain();
    write_reg(psm_pkg::REG_MATCH_MODE, 64'(psm_pkg::MODE_BEGINS));
    send_beat(8'h00, 1'b1, 1'b0);
    drain();

    base = beat_count;
    p = 0;
    while (beat_count - base < RANDOM_BEATS) begin
      configure_phase(p);
      phase_start = beat_count;
      while (beat_count - phase_start < PHASE_BEATS && beat_count - base < RANDOM_BEATS) begin
        send_subject(1'b1);
        if ($urandom_range(0, 29) == 0) drain();
      end
      if (p % 2 == 1) send_subject(1'b0);
      drain();
      p++;
    end

    drain();
    repeat (8) @(posedge clk);
    sb.report_leftover();
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/psm_pkg.sv
hdl/psm_cell.sv
hdl/prefix_substring_suffix_matcher.sv
tb/prefix_substring_suffix_matcher_tb.sv
